[src/pojq_pkg.sv]
// Shared types and constants for the policy-ordered job queue.
package pojq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 7;

    localparam int ID_W   = 20;
    localparam int TIME_W = 32;
    localparam int PROC_W = 16;
    localparam int RUN_W  = 32;
    localparam int JOB_W  = ID_W + TIME_W + PROC_W + RUN_W;

    localparam logic [1:0] MODE_ARRIVE = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    localparam logic [2:0] POL_FIFO     = 3'd0;
    localparam logic [2:0] POL_LARGEST  = 3'd1;
    localparam logic [2:0] POL_SMALLEST = 3'd2;
    localparam logic [2:0] POL_LONGEST  = 3'd3;
    localparam logic [2:0] POL_SHORTEST = 3'd4;
    localparam logic [2:0] POL_PROC_RUN = 3'd5;

    typedef struct packed {
        logic [RUN_W-1:0]  runtime;
        logic [PROC_W-1:0] procs;
        logic [TIME_W-1:0] arrival;
        logic [ID_W-1:0]   id;
    } job_t;

    // key compare: 1 ahead, 0 equal, -1 behind
    function automatic logic [1:0] key_cmp(input logic [31:0] x, input logic [31:0] y,
                                           input logic larger_first);
        logic [1:0] r;
        if (x == y)
            r = 2'b00;
        else if (larger_first)
            r = (x > y) ? 2'b01 : 2'b11;
        else
            r = (x < y) ? 2'b01 : 2'b11;
        return r;
    endfunction

    function automatic logic ranks_ahead(input job_t a, input job_t b, input logic [2:0] pol);
        logic [1:0] r;
        case (pol)
            POL_LARGEST:  r = key_cmp({16'd0, a.procs}, {16'd0, b.procs}, 1'b1);
            POL_SMALLEST: r = key_cmp({16'd0, a.procs}, {16'd0, b.procs}, 1'b0);
            POL_LONGEST:  r = key_cmp(a.runtime, b.runtime, 1'b1);
            POL_SHORTEST: r = key_cmp(a.runtime, b.runtime, 1'b0);
            POL_PROC_RUN:
            begin
                r = key_cmp({16'd0, a.procs}, {16'd0, b.procs}, 1'b1);
                if (r == 2'b00)
                    r = key_cmp(a.runtime, b.runtime, 1'b1);
            end
            default: r = 2'b00;
        endcase
        if (r == 2'b00)
            r = key_cmp(a.arrival, b.arrival, 1'b0);
        if (r == 2'b00)
            r = key_cmp({12'd0, a.id}, {12'd0, b.id}, 1'b0);
        return r == 2'b01;
    endfunction

endpackage

[src/pojq_store.sv]
// Job descriptor memory: one write port, one registered read port.
module pojq_store
    import pojq_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  job_t              wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output job_t              rd_data
);

    job_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

[src/policy_ordered_job_queue.sv]
// Top level of the policy-ordered job queue.
//
// s_axis carries one request per job event: arrive, try-start or clear,
// with the request kind on s_tuser. Each request gives exactly one result
// on m_axis: the started job or the current head, the occupancy after the
// request and an overflow flag. cfg_valid/cfg_data set the ordering policy;
// write it only while idle. The head is found by a linear scan of the
// descriptor memory, one entry per cycle through its registered read port.
// For each request the scan reads every job that the queue holds; a start
// then moves the last entry into the freed slot (S_MOVE reads it, S_MOVEW
// writes it), before S_DONE registers the result and S_OUT offers it.
// One request is in work at a time; s_tready is low while busy or while a
// result waits. A stalled receiver holds the result in the output register
// and the block takes no new request until it is taken.
// Reset clears the count and the policy; the memory is not cleared, as
// only entries below the count are read.
module policy_ordered_job_queue
    import pojq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[1:0]
    input  logic [1:0]   s_tuser,
    // job_number[19:0], arrival_time[51:20], procs_needed[67:52],
    // estimated_runtime[99:68], alloc_ok[100], zero fill to 104
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // started[0], head_valid[1]
    output logic [1:0]   m_tuser,
    // head_job_number[19:0], head_arrival_time[51:20], head_procs[67:52],
    // head_runtime[99:68], occupancy[106:100], overflow[107], zero fill to 112
    output logic [111:0] m_tdata
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_MOVE  = 6'b000100,
        S_MOVEW = 6'b001000,
        S_DONE  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0]        pol_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;    // next read address
    logic [ADDR_W-1:0] cmp_reg, cmp_next;    // address of data arriving
    logic              rd_pend_reg, rd_pend_next;
    logic [ADDR_W-1:0] best_slot_reg, best_slot_next;
    job_t              best_reg, best_next;
    logic              have_best_reg, have_best_next;
    logic              started_reg, started_next;
    logic              ovf_reg, ovf_next;
    job_t              started_job_reg, started_job_next;
    logic [109:0]      out_reg, out_next;
    // marks a start finished in this request
    logic              start_flag_reg, start_flag_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    job_t              wr_data, rd_data, in_job;
    logic [1:0]        in_mode;

    assign in_mode        = s_tuser;
    assign in_job.id      = s_tdata[19:0];
    assign in_job.arrival = s_tdata[51:20];
    assign in_job.procs   = s_tdata[67:52];
    assign in_job.runtime = s_tdata[99:68];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tuser   = out_reg[1:0];
    assign m_tdata   = {4'd0, out_reg[109:2]};

    pojq_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        cmp_next         = cmp_reg;
        rd_pend_next     = 1'b0;
        best_slot_next   = best_slot_reg;
        best_next        = best_reg;
        have_best_next   = have_best_reg;
        started_next     = started_reg;
        ovf_next         = ovf_reg;
        started_job_next = started_job_reg;
        out_next         = out_reg;
        wr_en            = 1'b0;
        wr_addr          = cnt_reg[ADDR_W-1:0];
        wr_data          = in_job;
        rd_addr          = idx_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    started_next   = 1'b0;
                    ovf_next       = 1'b0;
                    idx_next       = '0;
                    have_best_next = 1'b0;
                    state_next     = S_SCAN;
                    case (in_mode)
                        MODE_ARRIVE:
                        begin
                            if (cnt_reg >= CNT_W'(QUEUE_DEPTH))
                                ovf_next = 1'b1;
                            else
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        MODE_START:
                            started_next = (cnt_reg != '0) && s_tdata[100];
                        MODE_CLEAR:
                            cnt_next = '0;
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                // issue reads at idx, compare data from previous cycle
                if (rd_pend_reg)
                begin
                    if (!have_best_reg || ranks_ahead(rd_data, best_reg, pol_reg))
                    begin
                        best_next      = rd_data;
                        best_slot_next = cmp_reg;
                    end
                    have_best_next = 1'b1;
                end
                if (idx_reg < cnt_reg)
                begin
                    rd_pend_next = 1'b1;
                    cmp_next     = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                    state_next = started_reg ? S_MOVE : S_DONE;
            end
            S_MOVE:
            begin
                // started job is best; read last entry to fill its slot
                started_job_next = best_reg;
                rd_addr          = ADDR_W'(cnt_reg - 1'b1);
                state_next       = S_MOVEW;
            end
            S_MOVEW:
            begin
                wr_en          = 1'b1;
                wr_addr        = best_slot_reg;
                wr_data        = rd_data;
                cnt_next       = cnt_reg - 1'b1;
                started_next   = 1'b0;
                idx_next       = '0;
                have_best_next = 1'b0;
                // no rescan: the result reports the started job
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                out_next = '0;
                if (start_flag_reg)
                begin
                    out_next[0]      = 1'b1;
                    out_next[1]      = 1'b1;
                    out_next[101:2]  = {started_job_reg.runtime, started_job_reg.procs,
                                        started_job_reg.arrival, started_job_reg.id};
                end
                else if (cnt_reg != '0)
                begin
                    out_next[1]     = 1'b1;
                    out_next[101:2] = {best_reg.runtime, best_reg.procs,
                                       best_reg.arrival, best_reg.id};
                end
                out_next[108:102] = OCC_W'(cnt_reg);
                out_next[109]     = ovf_reg;
                state_next        = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        start_flag_next = start_flag_reg;
        if (state_reg == S_IDLE)
            start_flag_next = 1'b0;
        else if (state_reg == S_MOVEW)
            start_flag_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pol_reg        <= POL_FIFO;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            have_best_reg  <= 1'b0;
            started_reg    <= 1'b0;
            ovf_reg        <= 1'b0;
            start_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_pend_reg    <= rd_pend_next;
            have_best_reg  <= have_best_next;
            started_reg    <= started_next;
            ovf_reg        <= ovf_next;
            start_flag_reg <= start_flag_next;
            if (cfg_valid)
                pol_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        cmp_reg         <= cmp_next;
        best_slot_reg   <= best_slot_next;
        best_reg        <= best_next;
        started_job_reg <= started_job_next;
        out_reg         <= out_next;
    end

endmodule
